/* sv/mlsq_pkg.sv */
package mlsq_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int CLIENTS     = 8;
  localparam int PTR_W       = $clog2(QUEUE_SLOTS);
  localparam int CLIENT_W    = $clog2(CLIENTS);
  localparam int STAMP_W     = 32;
  localparam int SERVER_W    = 4;
  localparam int CMD_W       = 2;

  localparam logic [CMD_W-1:0] CMD_ACCESS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;

  localparam logic REPLY_GRANT = 1'b0;
  localparam logic REPLY_ACK   = 1'b1;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [CLIENT_W-1:0] client;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_GRANT
  } state_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    r = (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
    return r;
  endfunction

  function automatic ptr_t ptr_prev(input ptr_t p);
    ptr_t r;
    r = (p == '0) ? PTR_LAST : ptr_t'(p - 1'b1);
    return r;
  endfunction

  // true when the new request must stand ahead of the queued entry
  function automatic logic goes_before(input entry_t a, input entry_t b);
    logic r;
    r = (a.stamp < b.stamp) || ((a.stamp == b.stamp) && (a.client < b.client));
    return r;
  endfunction

endpackage

/* sv/mutex_lock_server_timestamp_queue.sv */
// Timing: a grant for a free lock or a release acknowledge is shown in the cycle after accept;
//   a handoff grant is loaded at the same edge that takes the acknowledge.
// Input hold: a queued insert holds the input for its accept, an S_SHIFT step per entry
//   moved back by the single compare and the final write; a handoff release waits in S_GRANT.
// Reset: clears lock, head/tail pointers, server id and output valid; queue storage is not
//   cleared, only entries between head and tail are ever used.
module mutex_lock_server_timestamp_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mlsq_pkg::CMD_W-1:0]        in_command,
  input  logic [mlsq_pkg::CLIENT_W-1:0]     in_requester_id,
  input  logic [mlsq_pkg::STAMP_W-1:0]      in_request_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_reply_kind,
  output logic [mlsq_pkg::CLIENT_W-1:0]     out_dest_client,
  output logic [mlsq_pkg::SERVER_W-1:0]     out_reply_server,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlsq_pkg::SERVER_W-1:0]     cfg_server_id
);

  mlsq_pkg::state_t state_r, state_nxt;

  logic                          lock_r, lock_nxt;
  mlsq_pkg::ptr_t                head_r, head_nxt;
  mlsq_pkg::ptr_t                tail_r, tail_nxt;
  mlsq_pkg::ptr_t                pos_r, pos_nxt;
  mlsq_pkg::entry_t              item_r, item_nxt;
  logic [mlsq_pkg::SERVER_W-1:0] server_r;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic [mlsq_pkg::CLIENT_W-1:0] out_dest_r, out_dest_nxt;
  logic [mlsq_pkg::SERVER_W-1:0] out_server_r, out_server_nxt;
  logic                          out_last_r, out_last_nxt;

  mlsq_pkg::entry_t queue_mem [mlsq_pkg::QUEUE_SLOTS];
  mlsq_pkg::entry_t rd_data_r;
  mlsq_pkg::ptr_t   rd_addr;
  mlsq_pkg::ptr_t   wr_addr;
  mlsq_pkg::entry_t wr_data;
  logic             wr_en;

  logic             out_free;
  logic             in_accept;
  logic             q_empty;
  logic             q_full;
  logic             at_head;
  logic             move_back;
  mlsq_pkg::entry_t in_entry;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == mlsq_pkg::S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign q_empty   = (head_r == tail_r);
  assign q_full    = (mlsq_pkg::ptr_next(tail_r) == head_r);
  assign at_head   = (pos_r == head_r);
  assign move_back = !at_head && mlsq_pkg::goes_before(item_r, rd_data_r);
  assign in_entry  = '{stamp: in_request_time, client: in_requester_id};

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_reply_kind   = out_kind_r;
  assign out_dest_client  = out_dest_r;
  assign out_reply_server = out_server_r;
  assign out_last         = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlsq_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_command == mlsq_pkg::CMD_ACCESS && lock_r && !q_full) begin
            state_nxt = mlsq_pkg::S_SHIFT;
          end else if (in_command == mlsq_pkg::CMD_RELEASE && !q_empty) begin
            state_nxt = mlsq_pkg::S_GRANT;
          end
        end
      end
      mlsq_pkg::S_SHIFT: begin
        if (!move_back) begin
          state_nxt = mlsq_pkg::S_IDLE;
        end
      end
      mlsq_pkg::S_GRANT: begin
        if (out_free) begin
          state_nxt = mlsq_pkg::S_IDLE;
        end
      end
      default: state_nxt = mlsq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lock_nxt       = lock_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    pos_nxt        = pos_r;
    item_nxt       = item_r;
    rd_addr        = head_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = item_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_dest_nxt   = out_dest_r;
    out_server_nxt = out_server_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      mlsq_pkg::S_IDLE: begin
        rd_addr = (in_command == mlsq_pkg::CMD_RELEASE) ? head_r : mlsq_pkg::ptr_prev(tail_r);
        pos_nxt  = tail_r;
        item_nxt = in_entry;
        if (in_accept) begin
          if (in_command == mlsq_pkg::CMD_ACCESS && !lock_r) begin
            lock_nxt       = 1'b1;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = mlsq_pkg::REPLY_GRANT;
            out_dest_nxt   = in_requester_id;
            out_server_nxt = server_r;
            out_last_nxt   = 1'b1;
          end else if (in_command == mlsq_pkg::CMD_RELEASE) begin
            // lock stays set when a waiter takes it over
            lock_nxt       = !q_empty;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = mlsq_pkg::REPLY_ACK;
            out_dest_nxt   = in_requester_id;
            out_server_nxt = server_r;
            out_last_nxt   = q_empty;
          end
        end
      end
      mlsq_pkg::S_SHIFT: begin
        // read one slot ahead of the slot that the next move writes
        rd_addr = mlsq_pkg::ptr_prev(mlsq_pkg::ptr_prev(pos_r));
        wr_en   = 1'b1;
        if (move_back) begin
          wr_data = rd_data_r;
          pos_nxt = mlsq_pkg::ptr_prev(pos_r);
        end else begin
          wr_data  = item_r;
          tail_nxt = mlsq_pkg::ptr_next(tail_r);
        end
      end
      mlsq_pkg::S_GRANT: begin
        rd_addr = head_r;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = mlsq_pkg::REPLY_GRANT;
          out_dest_nxt   = rd_data_r.client;
          out_server_nxt = server_r;
          out_last_nxt   = 1'b1;
          head_nxt       = mlsq_pkg::ptr_next(head_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= queue_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlsq_pkg::S_IDLE;
      lock_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      server_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lock_r      <= lock_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        server_r <= cfg_server_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    item_r       <= item_nxt;
    out_kind_r   <= out_kind_nxt;
    out_dest_r   <= out_dest_nxt;
    out_server_r <= out_server_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_shift_locked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mlsq_pkg::S_SHIFT |-> lock_r && !q_full)
    else $error("insert in progress while lock free or queue full");

  a_release_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_command == mlsq_pkg::CMD_RELEASE && !q_empty |=>
      state_r == mlsq_pkg::S_GRANT && out_valid_r && !out_last_r &&
      out_kind_r == mlsq_pkg::REPLY_ACK && lock_r)
    else $error("release with waiters did not queue a handoff grant");

  a_grant_pops: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mlsq_pkg::S_GRANT && out_free |=>
      head_r == mlsq_pkg::ptr_next($past(head_r)) && out_last_r &&
      out_kind_r == mlsq_pkg::REPLY_GRANT)
    else $error("handoff grant did not advance the queue head");
`endif

endmodule
